// ----- sv/plc_logical_address_parser_top_assert.svh -----
// Assertion macros shared by the logical address parser modules.
`ifndef PLC_LOGICAL_ADDRESS_PARSER_TOP_ASSERT_SVH
`define PLC_LOGICAL_ADDRESS_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, idle while rst is high.
`define PLAP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, idle while rst is high.
`define PLAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/plc_lap_pkg.sv -----
// Types, codes and lookup functions of the logical address parser.
`default_nettype none
package plc_lap_pkg;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_TYPE2  = 3'd1,
    PH_FFIRST = 3'd2,
    PH_FNUM   = 3'd3,
    PH_ELEM   = 3'd4,
    PH_MNEM   = 3'd5,
    PH_BIT    = 3'd6,
    PH_TAIL   = 3'd7
  } phase_t;

  // first letter of a two-letter prefix
  localparam logic [1:0] PL_B = 2'd0;
  localparam logic [1:0] PL_M = 2'd1;
  localparam logic [1:0] PL_P = 2'd2;
  localparam logic [1:0] PL_S = 2'd3;

  localparam logic [4:0] FT_UNKNOWN = 5'd0;
  localparam logic [4:0] FT_ASCII   = 5'd1;
  localparam logic [4:0] FT_BCD     = 5'd2;
  localparam logic [4:0] FT_BIT     = 5'd3;
  localparam logic [4:0] FT_BLOCK   = 5'd4;
  localparam logic [4:0] FT_BYTE    = 5'd5;
  localparam logic [4:0] FT_CONTROL = 5'd6;
  localparam logic [4:0] FT_COUNTER = 5'd7;
  localparam logic [4:0] FT_FLOAT   = 5'd8;
  localparam logic [4:0] FT_INPUT   = 5'd9;
  localparam logic [4:0] FT_INT     = 5'd10;
  localparam logic [4:0] FT_LONG    = 5'd11;
  localparam logic [4:0] FT_MESSAGE = 5'd12;
  localparam logic [4:0] FT_OUTPUT  = 5'd13;
  localparam logic [4:0] FT_PID     = 5'd14;
  localparam logic [4:0] FT_SFC     = 5'd15;
  localparam logic [4:0] FT_STATUS  = 5'd16;
  localparam logic [4:0] FT_STRING  = 5'd17;
  localparam logic [4:0] FT_TIMER   = 5'd18;

  localparam logic [19:0] NUM_LIMIT = 20'd65535;
  localparam logic [8:0]  BIT_LIMIT = 9'd32;
  localparam logic [2:0]  NO_WORD_LEN = 3'd7;

  typedef struct packed {
    logic              size_known;
    logic [6:0]        element_size;
    logic [7:0]        bit_number;
    logic              has_bit;
    logic signed [5:0] subelement;
    logic [19:0]       element_number;
    logic [19:0]       file_number;
    logic [4:0]        table_type;
    logic              status;
  } result_t;

  typedef struct packed {
    logic              hit;
    logic signed [5:0] sub;
    logic [4:0]        ftype;
  } lookup_t;

  typedef struct packed {
    logic       known;
    logic [6:0] size;
  } size_t;

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // v*10 + digit, kept to 20 bits
  function automatic logic [19:0] acc_digit(logic [19:0] v, logic [7:0] c);
    logic [23:0] t;
    t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {20'd0, c[3:0]};
    return t[19:0];
  endfunction

  // key and word hold up to four characters, first one in the top byte
  function automatic logic word_hit(logic [31:0] key, logic [2:0] len,
                                    logic [31:0] word, logic [2:0] wlen);
    logic ok;
    ok = (len == wlen);
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < wlen && key[8*(3-i) +: 8] != word[8*(3-i) +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic lookup_t hit_of(logic signed [5:0] sub, logic [4:0] ftype);
    lookup_t r;
    r.hit   = 1'b1;
    r.sub   = sub;
    r.ftype = ftype;
    return r;
  endfunction

  function automatic lookup_t mnem_lookup(logic [4:0] ftype, logic [31:0] key,
                                          logic [2:0] len);
    lookup_t r;
    r.hit   = 1'b0;
    r.sub   = -6'sd1;
    r.ftype = ftype;
    case (ftype)
      FT_BLOCK: begin
        if      (word_hit(key, len, "con ", 3'd3)) r = hit_of(6'sd0, FT_INT);
        else if (word_hit(key, len, "rlen", 3'd4)) r = hit_of(6'sd1, FT_INT);
        else if (word_hit(key, len, "dlen", 3'd4)) r = hit_of(6'sd2, FT_INT);
        else if (word_hit(key, len, "df  ", 3'd2)) r = hit_of(6'sd3, FT_INT);
        else if (word_hit(key, len, "elem", 3'd4)) r = hit_of(6'sd4, FT_INT);
        else if (word_hit(key, len, "rgs ", 3'd3)) r = hit_of(6'sd5, FT_INT);
      end
      FT_COUNTER, FT_TIMER: begin
        if      (word_hit(key, len, "con ", 3'd3)) r = hit_of(6'sd0, FT_INT);
        else if (word_hit(key, len, "pre ", 3'd3)) r = hit_of(6'sd1, FT_INT);
        else if (word_hit(key, len, "acc ", 3'd3)) r = hit_of(6'sd2, FT_INT);
      end
      FT_CONTROL: begin
        if      (word_hit(key, len, "con ", 3'd3)) r = hit_of(6'sd0, FT_INT);
        else if (word_hit(key, len, "len ", 3'd3)) r = hit_of(6'sd1, FT_INT);
        else if (word_hit(key, len, "pos ", 3'd3)) r = hit_of(6'sd2, FT_INT);
      end
      FT_PID: begin
        if      (word_hit(key, len, "con ", 3'd3)) r = hit_of(6'sd0, FT_UNKNOWN);
        else if (word_hit(key, len, "sp  ", 3'd2)) r = hit_of(6'sd2, FT_UNKNOWN);
        else if (word_hit(key, len, "kp  ", 3'd2)) r = hit_of(6'sd4, FT_UNKNOWN);
        else if (word_hit(key, len, "ki  ", 3'd2)) r = hit_of(6'sd6, FT_UNKNOWN);
        else if (word_hit(key, len, "kd  ", 3'd2)) r = hit_of(6'sd8, FT_UNKNOWN);
        else if (word_hit(key, len, "pv  ", 3'd2)) r = hit_of(6'sd26, FT_UNKNOWN);
      end
      FT_MESSAGE: begin
        if      (word_hit(key, len, "con ", 3'd3)) r = hit_of(6'sd0, FT_INT);
        else if (word_hit(key, len, "err ", 3'd3)) r = hit_of(6'sd1, FT_INT);
        else if (word_hit(key, len, "rlen", 3'd4)) r = hit_of(6'sd2, FT_INT);
        else if (word_hit(key, len, "dlen", 3'd4)) r = hit_of(6'sd3, FT_INT);
      end
      FT_STRING: begin
        if      (word_hit(key, len, "len ", 3'd3)) r = hit_of(6'sd0, FT_INT);
        else if (word_hit(key, len, "data", 3'd4)) r = hit_of(6'sd1, FT_BYTE);
      end
      default: ;
    endcase
    return r;
  endfunction

  // bytes per element; known clear for types with no supported size
  function automatic size_t elem_size(logic [4:0] ftype);
    size_t s;
    s.known = 1'b1;
    s.size  = 7'd0;
    case (ftype)
      FT_ASCII:   s.size = 7'd0;
      FT_BCD:     s.size = 7'd2;
      FT_BIT:     s.size = 7'd2;
      FT_BYTE:    s.size = 7'd1;
      FT_CONTROL: s.size = 7'd6;
      FT_COUNTER: s.size = 7'd6;
      FT_FLOAT:   s.size = 7'd4;
      FT_INPUT:   s.size = 7'd2;
      FT_INT:     s.size = 7'd2;
      FT_LONG:    s.size = 7'd4;
      FT_MESSAGE: s.size = 7'd112;
      FT_OUTPUT:  s.size = 7'd2;
      FT_PID:     s.size = 7'd0;
      FT_STATUS:  s.size = 7'd2;
      FT_STRING:  s.size = 7'd84;
      FT_TIMER:   s.size = 7'd6;
      default:    s.known = 1'b0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ----- sv/plc_logical_address_parser_top.sv -----
// Top level of the streaming PLC logical address parser.
//
//   channel   dir  payload                                         accepted when
//   s_axis    in   tdata[7:0] character                            tvalid && tready
//   m_axis    out  tdata[71:0] parsed address (see port comment)   tvalid && tready
//
// One character is taken every cycle while s_axis_tready is high; the parse state
// is updated in the same cycle. The zero byte that ends a name pushes its result
// into the buffer that feeds m_axis and puts the parse state back at its start.
// A two-entry result buffer absorbs output stalls; s_axis_tready falls only when
// both entries are full. rst is synchronous and clears all parse state.
`default_nettype none
module plc_logical_address_parser_top #(
  parameter int MNEMONIC_CHARS = 4
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] character
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [0] status, [5:1] table_type, [25:6] file_number, [45:26] element_number,
  // [51:46] subelement, [52] has_bit, [60:53] bit_number, [67:61] element_size,
  // [68] size_known, [71:69] zero
  output logic [71:0] m_axis_tdata
);

  localparam int IDX_W = $clog2(MNEMONIC_CHARS);
  localparam int LEN_W = $clog2(MNEMONIC_CHARS + 1);

  plc_lap_pkg::phase_t phase, phase_next;
  logic [4:0]          type_reg, type_reg_next;
  logic [1:0]          pending_letter, pending_letter_next;
  logic [19:0]         file_value, file_value_next;
  logic [19:0]         element_value, element_value_next;
  logic [7:0]          mnem_buf [MNEMONIC_CHARS];
  logic [LEN_W-1:0]    mnem_len, mnem_len_next;
  logic                mnem_seen, mnem_seen_next;
  logic                mnem_wr;
  logic [8:0]          bit_value, bit_value_next;
  logic                bit_seen, bit_seen_next;
  logic                error_flag, error_flag_next;

  logic                 accept;
  logic                 name_end;
  logic [7:0]           c;
  logic [7:0]           lc;
  logic                 digit;
  logic [31:0]          key;
  logic [2:0]           key_len;
  plc_lap_pkg::lookup_t found;
  plc_lap_pkg::size_t   fsize;
  plc_lap_pkg::result_t result;
  plc_lap_pkg::result_t out_data;
  logic                 buf_ready;
  logic [19:0]          bit_acc;

  assign c        = s_axis_tdata;
  assign lc       = plc_lap_pkg::lower(c);
  assign digit    = plc_lap_pkg::is_digit(c);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign name_end = accept && (c == 8'd0);
  assign s_axis_tready = buf_ready;
  assign bit_acc  = plc_lap_pkg::acc_digit({11'd0, bit_value}, c);

  // mnemonic key: lengths past four can never match a word
  assign key     = {mnem_buf[0], mnem_buf[1], mnem_buf[2], mnem_buf[3]};
  assign key_len = (mnem_len > LEN_W'(4)) ? plc_lap_pkg::NO_WORD_LEN : 3'(mnem_len);
  assign found   = plc_lap_pkg::mnem_lookup(type_reg, key, key_len);

  // next-state logic
  always_comb begin
    phase_next          = phase;
    type_reg_next       = type_reg;
    pending_letter_next = pending_letter;
    file_value_next     = file_value;
    element_value_next  = element_value;
    mnem_len_next       = mnem_len;
    mnem_seen_next      = mnem_seen;
    mnem_wr             = 1'b0;
    bit_value_next      = bit_value;
    bit_seen_next       = bit_seen;
    error_flag_next     = error_flag;
    if (name_end) begin
      phase_next          = plc_lap_pkg::PH_TYPE;
      type_reg_next       = plc_lap_pkg::FT_UNKNOWN;
      pending_letter_next = plc_lap_pkg::PL_B;
      file_value_next     = 20'd0;
      element_value_next  = 20'd0;
      mnem_len_next       = '0;
      mnem_seen_next      = 1'b0;
      bit_value_next      = 9'd0;
      bit_seen_next       = 1'b0;
      error_flag_next     = 1'b0;
    end else if (accept && !error_flag) begin
      case (phase)
        plc_lap_pkg::PH_TYPE: begin
          phase_next = plc_lap_pkg::PH_FFIRST;
          case (lc)
            "a": type_reg_next = plc_lap_pkg::FT_ASCII;
            "c": type_reg_next = plc_lap_pkg::FT_COUNTER;
            "d": type_reg_next = plc_lap_pkg::FT_BCD;
            "f": type_reg_next = plc_lap_pkg::FT_FLOAT;
            "i": type_reg_next = plc_lap_pkg::FT_INPUT;
            "l": type_reg_next = plc_lap_pkg::FT_LONG;
            "n": type_reg_next = plc_lap_pkg::FT_INT;
            "o": type_reg_next = plc_lap_pkg::FT_OUTPUT;
            "r": type_reg_next = plc_lap_pkg::FT_CONTROL;
            "t": type_reg_next = plc_lap_pkg::FT_TIMER;
            "b": begin
              pending_letter_next = plc_lap_pkg::PL_B;
              phase_next = plc_lap_pkg::PH_TYPE2;
            end
            "m": begin
              pending_letter_next = plc_lap_pkg::PL_M;
              phase_next = plc_lap_pkg::PH_TYPE2;
            end
            "p": begin
              pending_letter_next = plc_lap_pkg::PL_P;
              phase_next = plc_lap_pkg::PH_TYPE2;
            end
            "s": begin
              pending_letter_next = plc_lap_pkg::PL_S;
              phase_next = plc_lap_pkg::PH_TYPE2;
            end
            default: error_flag_next = 1'b1;
          endcase
        end
        plc_lap_pkg::PH_TYPE2: begin
          phase_next = plc_lap_pkg::PH_FFIRST;
          // B and S alone are bit and status files: the digit opens the file number
          if ((pending_letter == plc_lap_pkg::PL_B || pending_letter == plc_lap_pkg::PL_S)
              && digit) begin
            type_reg_next   = (pending_letter == plc_lap_pkg::PL_B) ?
                              plc_lap_pkg::FT_BIT : plc_lap_pkg::FT_STATUS;
            file_value_next = plc_lap_pkg::acc_digit(20'd0, c);
            phase_next      = plc_lap_pkg::PH_FNUM;
          end else if (pending_letter == plc_lap_pkg::PL_B && lc == "t") begin
            type_reg_next = plc_lap_pkg::FT_BLOCK;
          end else if (pending_letter == plc_lap_pkg::PL_M && lc == "g") begin
            type_reg_next = plc_lap_pkg::FT_MESSAGE;
          end else if (pending_letter == plc_lap_pkg::PL_P && lc == "d") begin
            type_reg_next = plc_lap_pkg::FT_PID;
          end else if (pending_letter == plc_lap_pkg::PL_S && lc == "c") begin
            type_reg_next = plc_lap_pkg::FT_SFC;
          end else if (pending_letter == plc_lap_pkg::PL_S && lc == "t") begin
            type_reg_next = plc_lap_pkg::FT_STRING;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        plc_lap_pkg::PH_FFIRST: begin
          if (digit) begin
            file_value_next = plc_lap_pkg::acc_digit(20'd0, c);
            phase_next      = plc_lap_pkg::PH_FNUM;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        plc_lap_pkg::PH_FNUM: begin
          if (digit && file_value < plc_lap_pkg::NUM_LIMIT)
            file_value_next = plc_lap_pkg::acc_digit(file_value, c);
          else if (c == ":")
            phase_next = plc_lap_pkg::PH_ELEM;
          else
            error_flag_next = 1'b1;
        end
        plc_lap_pkg::PH_ELEM: begin
          if (digit && element_value < plc_lap_pkg::NUM_LIMIT) begin
            element_value_next = plc_lap_pkg::acc_digit(element_value, c);
          end else if (c == ".") begin
            mnem_seen_next = 1'b1;
            mnem_len_next  = '0;
            phase_next     = plc_lap_pkg::PH_MNEM;
          end else if (c == "/") begin
            bit_seen_next = 1'b1;
            phase_next    = plc_lap_pkg::PH_BIT;
          end else begin
            error_flag_next = 1'b1;
          end
        end
        plc_lap_pkg::PH_MNEM: begin
          if (c == "/") begin
            if (found.hit) begin
              bit_seen_next = 1'b1;
              phase_next    = plc_lap_pkg::PH_BIT;
            end else begin
              error_flag_next = 1'b1;
            end
          end else if (mnem_len < LEN_W'(MNEMONIC_CHARS)) begin
            mnem_wr       = 1'b1;
            mnem_len_next = mnem_len + LEN_W'(1);
          end else begin
            error_flag_next = 1'b1;
          end
        end
        plc_lap_pkg::PH_BIT: begin
          if (digit && bit_value < plc_lap_pkg::BIT_LIMIT)
            bit_value_next = bit_acc[8:0];
          else
            phase_next = plc_lap_pkg::PH_TAIL;
        end
        default: ;
      endcase
    end
  end

  // result of the name that ends with this item
  always_comb begin
    logic [4:0]        ftype;
    logic signed [5:0] sub;
    logic              bad;
    ftype = type_reg;
    sub   = -6'sd1;
    bad   = error_flag || phase == plc_lap_pkg::PH_TYPE || phase == plc_lap_pkg::PH_TYPE2
            || phase == plc_lap_pkg::PH_FFIRST || phase == plc_lap_pkg::PH_FNUM
            || (mnem_seen && !found.hit);
    if (mnem_seen && found.hit) begin
      ftype = found.ftype;
      sub   = found.sub;
    end
    fsize = plc_lap_pkg::elem_size(ftype);
    if (bad) begin
      result            = '0;
      result.status     = 1'b1;
      result.subelement = -6'sd1;
    end else begin
      result.status         = 1'b0;
      result.table_type     = ftype;
      result.file_number    = file_value;
      result.element_number = element_value;
      result.subelement     = sub;
      result.has_bit        = bit_seen;
      result.bit_number     = bit_value[7:0];
      result.element_size   = fsize.known ? fsize.size : 7'd0;
      result.size_known     = fsize.known;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= plc_lap_pkg::PH_TYPE;
      type_reg       <= plc_lap_pkg::FT_UNKNOWN;
      pending_letter <= plc_lap_pkg::PL_B;
      file_value     <= 20'd0;
      element_value  <= 20'd0;
      mnem_len       <= '0;
      mnem_seen      <= 1'b0;
      bit_value      <= 9'd0;
      bit_seen       <= 1'b0;
      error_flag     <= 1'b0;
    end else begin
      phase          <= phase_next;
      type_reg       <= type_reg_next;
      pending_letter <= pending_letter_next;
      file_value     <= file_value_next;
      element_value  <= element_value_next;
      mnem_len       <= mnem_len_next;
      mnem_seen      <= mnem_seen_next;
      bit_value      <= bit_value_next;
      bit_seen       <= bit_seen_next;
      error_flag     <= error_flag_next;
    end
  end

  // characters are stored folded to lower case; only entries below mnem_len are read
  always_ff @(posedge clk) begin
    if (mnem_wr) mnem_buf[mnem_len[IDX_W-1:0]] <= lc;
  end

  plc_lap_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (name_end),
    .push_data  (result),
    .push_ready (buf_ready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_data)
  );

  assign m_axis_tdata = {3'b000, out_data};

`include "plc_logical_address_parser_top_assert.svh"

  `PLAP_ASSERT_NEXT(a_name_end_restarts, name_end,
    phase == plc_lap_pkg::PH_TYPE && !error_flag && !mnem_seen && !bit_seen,
    "parser not back at start after end of name")
  `PLAP_ASSERT_NOW(a_mnem_flag, phase == plc_lap_pkg::PH_MNEM, mnem_seen,
    "in mnemonic phase without mnemonic flag")
  `PLAP_ASSERT_NOW(a_bit_phase, bit_seen,
    phase == plc_lap_pkg::PH_BIT || phase == plc_lap_pkg::PH_TAIL,
    "bit flag set outside bit phases")

endmodule
`default_nettype wire

// ----- sv/plc_lap_outbuf.sv -----
// Two-entry result buffer: output register plus skid register.
`default_nettype none
module plc_lap_outbuf (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  plc_lap_pkg::result_t  push_data,
  output logic                  push_ready,
  output logic                  out_valid,
  input  wire                   out_ready,
  output plc_lap_pkg::result_t  out_data
);

  logic                 skid_valid;
  plc_lap_pkg::result_t skid_data;
  logic                 pop;

  assign pop        = out_valid && out_ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (push) begin
      if (!out_valid || pop) out_data <= push_data;
      else skid_data <= push_data;
    end
  end

`include "plc_logical_address_parser_top_assert.svh"

  `PLAP_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid holds an item but output is empty")
  `PLAP_ASSERT_NEXT(a_skid_fills, push && !skid_valid && out_valid && !pop, skid_valid, "stalled item not parked in skid")
  `PLAP_ASSERT_NEXT(a_skid_drains, pop && skid_valid, out_valid && !skid_valid, "skid item not moved to output")

endmodule
`default_nettype wire

// ----- test/tb_plc_logical_address_parser_top.sv -----
// Self-checking testbench for the streaming PLC logical address parser.
`default_nettype none
module tb_plc_logical_address_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_CHARS = 4;
  localparam int IDLE_LIMIT = 1000;
  localparam logic [7:0] NO_SIZE = 8'hFF;

  typedef enum logic [1:0] {RX_READY, RX_CHOPPY, RX_SLOW} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  plc_logical_address_parser_top #(.MNEMONIC_CHARS(WORD_CHARS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // parser state as seen by the predictor
  plc_lap_pkg::phase_t ps_phase;
  logic [4:0]  ps_type;
  logic [7:0]  ps_lead;      // first letter of a two-letter prefix
  logic [19:0] ps_file;
  logic [19:0] ps_elem;
  logic [31:0] ps_word;      // lower-case field word, last character in the low byte
  int          ps_word_len;
  logic        ps_has_word;
  logic [8:0]  ps_bit;
  logic        ps_has_bit;
  logic        ps_bad;

  plc_lap_pkg::result_t expected_addresses[$];
  logic [7:0]  name_chars[$];
  int          fail_count = 0;
  int          chars_sent = 0;
  int          names_checked = 0;
  int          names_rejected = 0;
  logic [31:0] types_seen = '0;
  int          burst_left = 0;
  logic        tx_gaps = 1'b0;
  rx_mode_t    rx_mode = RX_READY;
  int          rx_hold = 0;
  int          idle_cycles = 0;

  string prefixes[17] = '{"a", "c", "d", "f", "i", "l", "n", "o", "r", "t",
                          "b", "bt", "mg", "pd", "s", "sc", "st"};

  function automatic void clear_parse();
    ps_phase    = plc_lap_pkg::PH_TYPE;
    ps_type     = plc_lap_pkg::FT_UNKNOWN;
    ps_lead     = 8'd0;
    ps_file     = 20'd0;
    ps_elem     = 20'd0;
    ps_word     = 32'd0;
    ps_word_len = 0;
    ps_has_word = 1'b0;
    ps_bit      = 9'd0;
    ps_has_bit  = 1'b0;
    ps_bad      = 1'b0;
  endfunction

  function automatic logic is_decimal(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [19:0] decimal_step(logic [19:0] v, logic [7:0] c);
    return 20'(v * 20'd10 + 20'(c - "0"));
  endfunction

  // field index and resulting type for a word on a given file type
  function automatic logic field_of(input logic [4:0] ft, input logic [31:0] w,
                                    output logic signed [5:0] sub, output logic [4:0] nft);
    sub = -6'sd1;
    case (ft)
      plc_lap_pkg::FT_BLOCK:
        case (w)
          32'("con"):  sub = 6'sd0;
          32'("rlen"): sub = 6'sd1;
          32'("dlen"): sub = 6'sd2;
          32'("df"):   sub = 6'sd3;
          32'("elem"): sub = 6'sd4;
          32'("rgs"):  sub = 6'sd5;
          default: ;
        endcase
      plc_lap_pkg::FT_COUNTER, plc_lap_pkg::FT_TIMER:
        case (w)
          32'("con"): sub = 6'sd0;
          32'("pre"): sub = 6'sd1;
          32'("acc"): sub = 6'sd2;
          default: ;
        endcase
      plc_lap_pkg::FT_CONTROL:
        case (w)
          32'("con"): sub = 6'sd0;
          32'("len"): sub = 6'sd1;
          32'("pos"): sub = 6'sd2;
          default: ;
        endcase
      plc_lap_pkg::FT_PID:
        case (w)
          32'("con"): sub = 6'sd0;
          32'("sp"):  sub = 6'sd2;
          32'("kp"):  sub = 6'sd4;
          32'("ki"):  sub = 6'sd6;
          32'("kd"):  sub = 6'sd8;
          32'("pv"):  sub = 6'sd26;
          default: ;
        endcase
      plc_lap_pkg::FT_MESSAGE:
        case (w)
          32'("con"):  sub = 6'sd0;
          32'("err"):  sub = 6'sd1;
          32'("rlen"): sub = 6'sd2;
          32'("dlen"): sub = 6'sd3;
          default: ;
        endcase
      plc_lap_pkg::FT_STRING:
        case (w)
          32'("len"):  sub = 6'sd0;
          32'("data"): sub = 6'sd1;
          default: ;
        endcase
      default: ;
    endcase
    nft = ft;
    if (sub != -6'sd1) begin
      if (ft == plc_lap_pkg::FT_PID) nft = plc_lap_pkg::FT_UNKNOWN;
      else if (ft == plc_lap_pkg::FT_STRING && w == 32'("data")) nft = plc_lap_pkg::FT_BYTE;
      else nft = plc_lap_pkg::FT_INT;
    end
    return sub != -6'sd1;
  endfunction

  function automatic logic [7:0] bytes_per_element(logic [4:0] ft);
    case (ft)
      plc_lap_pkg::FT_ASCII, plc_lap_pkg::FT_PID: return 8'd0;
      plc_lap_pkg::FT_BYTE: return 8'd1;
      plc_lap_pkg::FT_BCD, plc_lap_pkg::FT_BIT, plc_lap_pkg::FT_INPUT,
      plc_lap_pkg::FT_INT, plc_lap_pkg::FT_OUTPUT, plc_lap_pkg::FT_STATUS: return 8'd2;
      plc_lap_pkg::FT_FLOAT, plc_lap_pkg::FT_LONG: return 8'd4;
      plc_lap_pkg::FT_CONTROL, plc_lap_pkg::FT_COUNTER, plc_lap_pkg::FT_TIMER: return 8'd6;
      plc_lap_pkg::FT_STRING: return 8'd84;
      plc_lap_pkg::FT_MESSAGE: return 8'd112;
      default: return NO_SIZE;
    endcase
  endfunction

  // advance the predicted parse by one character; 1 when an address is due
  function automatic logic parse_char(input logic [7:0] c, output plc_lap_pkg::result_t r);
    logic [7:0]        lc;
    logic [7:0]        sz;
    logic signed [5:0] sub;
    logic [4:0]        ft;
    logic              bad;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    r  = '0;
    if (c == 8'd0) begin
      sub = -6'sd1;
      ft  = ps_type;
      bad = ps_bad || ps_phase <= plc_lap_pkg::PH_FNUM;
      if (!bad && ps_has_word && !field_of(ps_type, ps_word, sub, ft)) bad = 1'b1;
      if (bad) begin
        r.status     = 1'b1;
        r.subelement = -6'sd1;
      end else begin
        sz               = bytes_per_element(ft);
        r.table_type     = ft;
        r.file_number    = ps_file;
        r.element_number = ps_elem;
        r.subelement     = sub;
        r.has_bit        = ps_has_bit;
        r.bit_number     = ps_bit[7:0];
        r.element_size   = (sz == NO_SIZE) ? 7'd0 : sz[6:0];
        r.size_known     = (sz != NO_SIZE);
      end
      clear_parse();
      return 1'b1;
    end
    if (ps_bad) return 1'b0;
    case (ps_phase)
      plc_lap_pkg::PH_TYPE: begin
        ps_phase = plc_lap_pkg::PH_FFIRST;
        case (lc)
          "a": ps_type = plc_lap_pkg::FT_ASCII;
          "c": ps_type = plc_lap_pkg::FT_COUNTER;
          "d": ps_type = plc_lap_pkg::FT_BCD;
          "f": ps_type = plc_lap_pkg::FT_FLOAT;
          "i": ps_type = plc_lap_pkg::FT_INPUT;
          "l": ps_type = plc_lap_pkg::FT_LONG;
          "n": ps_type = plc_lap_pkg::FT_INT;
          "o": ps_type = plc_lap_pkg::FT_OUTPUT;
          "r": ps_type = plc_lap_pkg::FT_CONTROL;
          "t": ps_type = plc_lap_pkg::FT_TIMER;
          "b", "m", "p", "s": begin
            ps_lead  = lc;
            ps_phase = plc_lap_pkg::PH_TYPE2;
          end
          default: ps_bad = 1'b1;
        endcase
      end
      plc_lap_pkg::PH_TYPE2: begin
        ps_phase = plc_lap_pkg::PH_FFIRST;
        // B and S followed straight by a digit are bit and status files
        if ((ps_lead == "b" || ps_lead == "s") && is_decimal(c)) begin
          ps_type  = (ps_lead == "b") ? plc_lap_pkg::FT_BIT : plc_lap_pkg::FT_STATUS;
          ps_file  = decimal_step(20'd0, c);
          ps_phase = plc_lap_pkg::PH_FNUM;
        end else if (ps_lead == "b" && lc == "t") ps_type = plc_lap_pkg::FT_BLOCK;
        else if (ps_lead == "m" && lc == "g") ps_type = plc_lap_pkg::FT_MESSAGE;
        else if (ps_lead == "p" && lc == "d") ps_type = plc_lap_pkg::FT_PID;
        else if (ps_lead == "s" && lc == "c") ps_type = plc_lap_pkg::FT_SFC;
        else if (ps_lead == "s" && lc == "t") ps_type = plc_lap_pkg::FT_STRING;
        else ps_bad = 1'b1;
      end
      plc_lap_pkg::PH_FFIRST: begin
        if (is_decimal(c)) begin
          ps_file  = decimal_step(20'd0, c);
          ps_phase = plc_lap_pkg::PH_FNUM;
        end else ps_bad = 1'b1;
      end
      plc_lap_pkg::PH_FNUM: begin
        if (is_decimal(c) && ps_file < plc_lap_pkg::NUM_LIMIT) ps_file = decimal_step(ps_file, c);
        else if (c == ":") ps_phase = plc_lap_pkg::PH_ELEM;
        else ps_bad = 1'b1;
      end
      plc_lap_pkg::PH_ELEM: begin
        if (is_decimal(c) && ps_elem < plc_lap_pkg::NUM_LIMIT) ps_elem = decimal_step(ps_elem, c);
        else if (c == ".") begin
          ps_has_word = 1'b1;
          ps_word     = 32'd0;
          ps_word_len = 0;
          ps_phase    = plc_lap_pkg::PH_MNEM;
        end else if (c == "/") begin
          ps_has_bit = 1'b1;
          ps_phase   = plc_lap_pkg::PH_BIT;
        end else ps_bad = 1'b1;
      end
      plc_lap_pkg::PH_MNEM: begin
        if (c == "/") begin
          if (field_of(ps_type, ps_word, sub, ft)) begin
            ps_has_bit = 1'b1;
            ps_phase   = plc_lap_pkg::PH_BIT;
          end else ps_bad = 1'b1;
        end else if (ps_word_len < WORD_CHARS) begin
          ps_word     = {ps_word[23:0], lc};
          ps_word_len = ps_word_len + 1;
        end else ps_bad = 1'b1;
      end
      plc_lap_pkg::PH_BIT: begin
        if (is_decimal(c) && ps_bit < plc_lap_pkg::BIT_LIMIT)
          ps_bit = 9'(ps_bit * 9'd10 + 9'(c - "0"));
        else ps_phase = plc_lap_pkg::PH_TAIL;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("address %0d %s got %0h want %0h", names_checked, what, got, want));
  endtask

  // result checking, then prediction of the item accepted at the same edge
  always @(posedge clk) begin
    plc_lap_pkg::result_t got_r;
    plc_lap_pkg::result_t want_r;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = plc_lap_pkg::result_t'(m_axis_tdata[68:0]);
        if (expected_addresses.size() == 0) begin
          report_error("address result with none outstanding");
        end else begin
          want_r = expected_addresses.pop_front();
          check_field("status", got_r.status, want_r.status);
          check_field("table_type", got_r.table_type, want_r.table_type);
          check_field("file_number", got_r.file_number, want_r.file_number);
          check_field("element_number", got_r.element_number, want_r.element_number);
          check_field("subelement", got_r.subelement, want_r.subelement);
          check_field("has_bit", got_r.has_bit, want_r.has_bit);
          check_field("bit_number", got_r.bit_number, want_r.bit_number);
          check_field("element_size", got_r.element_size, want_r.element_size);
          check_field("size_known", got_r.size_known, want_r.size_known);
          check_field("padding", m_axis_tdata[71:69], 3'd0);
          if (want_r.status) names_rejected++;
          else types_seen[want_r.table_type] = 1'b1;
        end
        names_checked++;
      end
      if (s_axis_tvalid && s_axis_tready && parse_char(s_axis_tdata, want_r))
        expected_addresses.push_back(want_r);
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      case (rx_mode)
        RX_READY: m_axis_tready <= 1'b1;
        RX_CHOPPY: begin
          m_axis_tready <= ($urandom_range(0, 2) != 0);
          rx_hold       <= $urandom_range(0, 3);
        end
        default: begin
          if (m_axis_tready) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= $urandom_range(4, 20);
          end else begin
            m_axis_tready <= 1'b1;
            rx_hold       <= $urandom_range(0, 2);
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = tx_gaps ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char(8'd0);
  endtask

  task automatic send_name_chars();
    foreach (name_chars[i]) send_char(name_chars[i]);
  endtask

  // sender holds off until every predicted address has come back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_addresses.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_case(logic [7:0] c);
    return (c >= "a" && c <= "z" && $urandom_range(0, 1) != 0) ? c - 8'd32 : c;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) name_chars.push_back(any_case(s[i]));
  endfunction

  function automatic void add_digits(int n);
    for (int i = 0; i < n; i++) name_chars.push_back(8'("0" + $urandom_range(0, 9)));
  endfunction

  function automatic string field_word_for(int prefix_idx);
    string w[$];
    case (prefixes[prefix_idx])
      "c", "t": w = '{"con", "pre", "acc"};
      "r":      w = '{"con", "len", "pos"};
      "bt":     w = '{"con", "rlen", "dlen", "df", "elem", "rgs"};
      "mg":     w = '{"con", "err", "rlen", "dlen"};
      "pd":     w = '{"con", "sp", "kp", "ki", "kd", "pv"};
      "st":     w = '{"len", "data"};
      default:  w = '{"len", "acc", "data"};
    endcase
    return w[$urandom_range(0, w.size() - 1)];
  endfunction

  // mostly well-formed addresses with random content, some broken or pure noise
  function automatic void build_random_name();
    int pick;
    int kind;
    int cut;
    pick = $urandom_range(0, 16);
    name_chars.delete();
    add_text(prefixes[pick]);
    add_digits(($urandom_range(0, 9) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3));
    name_chars.push_back(":");
    add_digits(($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3));
    if ($urandom_range(0, 9) < 4) begin
      name_chars.push_back(".");
      if ($urandom_range(0, 4) != 0) begin
        add_text(field_word_for(pick));
      end else begin
        repeat ($urandom_range(0, 5))
          name_chars.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                           : 8'("a" + $urandom_range(0, 25)));
      end
    end
    if ($urandom_range(0, 9) < 4) begin
      name_chars.push_back("/");
      add_digits($urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) name_chars.push_back(8'($urandom_range(1, 255)));
    end
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      cut = $urandom_range(0, name_chars.size() - 1);
      while (name_chars.size() > cut) void'(name_chars.pop_back());
    end else if (kind == 1) begin
      name_chars.insert($urandom_range(0, name_chars.size()), 8'($urandom_range(1, 255)));
    end else if (kind == 2) begin
      name_chars.delete();
      repeat ($urandom_range(1, 6)) name_chars.push_back(8'($urandom_range(1, 255)));
    end
    name_chars.push_back(8'd0);
  endfunction

  task automatic test_plain_addresses();
    tx_gaps = 1'b0;
    rx_mode = RX_READY;
    send_text("");
    send_text("N7:0/3");
    send_text("S2:1");
    send_text("sc1:0");
  endtask

  task automatic test_field_words();
    tx_gaps = 1'b1;
    rx_mode = RX_CHOPPY;
    send_text("T4:2.ACC/31");
    send_text("st9:1.data");
    send_text("PD9:0.pv");
    send_text("MG9:0.RLEN/15");
    send_text("bt1:0.Elem");
  endtask

  task automatic test_number_limits();
    rx_mode = RX_SLOW;
    send_text("B65535:655349/319z");
    send_text("N655349:0");
    send_text("N655350:0");
    send_text("S2:0/");
  endtask

  task automatic test_malformed_names();
    rx_mode = RX_CHOPPY;
    send_text("N7");
    send_text("Z1:0");
    send_text("BX1:0");
    send_text("T4:0.ACCUM");
    send_text("N7:0.");
    send_text("N7:0.acc/1");
    send_text("C5:0:1");
    send_char(8'hFF);
    send_char(8'd0);
  endtask

  task automatic test_random_names();
    int target;
    for (int part = 0; part < 4; part++) begin
      tx_gaps = (part != 0);
      rx_mode = (part == 0) ? RX_READY : (part == 2) ? RX_SLOW : RX_CHOPPY;
      target  = chars_sent + 145;
      while (chars_sent < target) begin
        build_random_name();
        send_name_chars();
      end
      if (part == 1) wait_for_results();
    end
  endtask

  initial begin
    clear_parse();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_plain_addresses();
    test_field_words();
    wait_for_results();
    test_number_limits();
    test_malformed_names();
    test_random_names();
    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d addresses from %0d characters, %0d of them malformed;",
             names_checked, chars_sent, names_rejected);
    $display("%0d of 19 file types decoded, under varied source gaps and sink stalls.",
             $countones(types_seen));
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+sv
sv/plc_lap_pkg.sv
sv/plc_lap_outbuf.sv
sv/plc_logical_address_parser_top.sv
test/tb_plc_logical_address_parser_top.sv
